// ----- sv/mmss_pkg.sv -----
`timescale 1ns / 1ps
// shared types, constants and digit helpers for the mm:ss set-and-count timer
// no dependencies

package mmss_pkg;

    localparam int ADC_BITS  = 10;
    localparam int POT_W     = 10;
    localparam int CNT_W     = 6;
    localparam int SEG_W     = 7;
    localparam int LED_W     = 4;
    localparam int IN_DATA_W = 16;
    localparam int OUT_DATA_W = 40;

    localparam logic [CNT_W-1:0] SEC_LAST  = 6'd59;
    localparam logic [5:0]       POT_SCALE = 6'd60;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_ARM_MIN = 3'd1,
        PH_SET_MIN = 3'd2,
        PH_ARM_SEC = 3'd3,
        PH_SET_SEC = 3'd4,
        PH_ARM_RUN = 3'd5,
        PH_COUNT   = 3'd6
    } t_phase;

    typedef struct packed {
        t_phase            phase;
        logic [CNT_W-1:0]  minutes;
        logic [CNT_W-1:0]  seconds;
    } t_shown;

    localparam logic [SEG_W-1:0] SEG_TABLE [10] = '{
        7'h7E, 7'h30, 7'h6D, 7'h79, 7'h33, 7'h5B, 7'h5F, 7'h70, 7'h7F, 7'h7B
    };

    function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] d);
        logic [SEG_W-1:0] s;
        s = 7'h00;
        if (d < 4'd10) begin
            s = SEG_TABLE[d];
        end
        return s;
    endfunction

    function automatic logic [2:0] tens_of(input logic [CNT_W-1:0] v);
        logic [2:0] t;
        if (v >= 6'd60)      t = 3'd6;
        else if (v >= 6'd50) t = 3'd5;
        else if (v >= 6'd40) t = 3'd4;
        else if (v >= 6'd30) t = 3'd3;
        else if (v >= 6'd20) t = 3'd2;
        else if (v >= 6'd10) t = 3'd1;
        else                 t = 3'd0;
        return t;
    endfunction

    function automatic logic [3:0] ones_of(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        case (tens_of(v))
            3'd6:    r = v - 6'd60;
            3'd5:    r = v - 6'd50;
            3'd4:    r = v - 6'd40;
            3'd3:    r = v - 6'd30;
            3'd2:    r = v - 6'd20;
            3'd1:    r = v - 6'd10;
            default: r = v;
        endcase
        return r[3:0];
    endfunction

endpackage

// ----- sv/set_and_count_minute_second_timer.sv -----
`timescale 1ns / 1ps
// mm:ss set-and-count timer: input register, sequencer, display decode, output register
// depends on mmss_pkg, mmss_ctrl, mmss_disp
//
// usage
// - slave channel s_*: one sample per transfer (set button level, pot reading, tick)
// - master channel m_*: one result per sample, four seven-segment patterns,
//   phase leds and the counting flag
// - the button steps the phases on alternating levels; the pot sets minutes,
//   then seconds; the sixth step latches the limits and counting starts,
//   one second per tick, back to idle one tick after the limits are shown
// - the sample is registered in the input register and its result in the
//   output register; a stalled master side can hold it in between
// - one sample per cycle while the master side takes results; the sequencer
//   state updates in a single pass between input and output register
// - a stalled master side holds the result; the input register keeps
//   taking a sample while the output register is empty or being drained,
//   so s_tready follows m_tready when both stages are full
// - reset (synchronous, active low) empties both stages and returns to
//   idle with counters and limits at zero

module set_and_count_minute_second_timer (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // set_button[0], pot_reading[10:1], tick[11], zero[15:12]
    input  logic [mmss_pkg::IN_DATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // min_tens_seg[6:0], min_ones_seg[13:7], sec_tens_seg[20:14],
    // sec_ones_seg[27:21], phase_leds[31:28], counting[32], zero[39:33]
    output logic [mmss_pkg::OUT_DATA_W-1:0]    m_tdata
);

    logic                                r_in_valid;
    logic [mmss_pkg::IN_DATA_W-1:0]      r_in_data;
    logic                                r_out_valid;
    logic [mmss_pkg::OUT_DATA_W-1:0]     r_out_data;
    logic                                step;
    mmss_pkg::t_shown                    shown;
    logic [mmss_pkg::SEG_W-1:0]          min_tens_seg, min_ones_seg;
    logic [mmss_pkg::SEG_W-1:0]          sec_tens_seg, sec_ones_seg;
    logic [mmss_pkg::LED_W-1:0]          phase_leds;
    logic                                counting;

    assign step     = r_in_valid && (!r_out_valid || m_tready);
    assign s_tready = !r_in_valid || step;
    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;

    mmss_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_set_button  (r_in_data[0]),
        .i_pot_reading (r_in_data[10:1]),
        .i_tick        (r_in_data[11]),
        .o_shown       (shown)
    );

    mmss_disp u_disp (
        .i_shown        (shown),
        .o_min_tens_seg (min_tens_seg),
        .o_min_ones_seg (min_ones_seg),
        .o_sec_tens_seg (sec_tens_seg),
        .o_sec_ones_seg (sec_ones_seg),
        .o_phase_leds   (phase_leds),
        .o_counting     (counting)
    );

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_tready) begin
                r_in_valid <= s_tvalid;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (s_tready && s_tvalid) begin
            r_in_data <= s_tdata;
        end
        if (step) begin
            r_out_data <= {7'd0, counting, phase_leds, sec_ones_seg, sec_tens_seg,
                           min_ones_seg, min_tens_seg};
        end
    end

endmodule

// ----- sv/mmss_ctrl.sv -----
`timescale 1ns / 1ps
// phase sequencer, minute/second counters and limits of the timer
// depends on mmss_pkg

module mmss_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic                        i_set_button,
    input  logic [mmss_pkg::POT_W-1:0]  i_pot_reading,
    input  logic                        i_tick,
    output mmss_pkg::t_shown            o_shown
);

    mmss_pkg::t_phase              r_phase, n_phase;
    logic [mmss_pkg::CNT_W-1:0]    r_minutes, n_minutes;
    logic [mmss_pkg::CNT_W-1:0]    r_seconds, n_seconds;
    logic [mmss_pkg::CNT_W-1:0]    r_minute_limit, n_minute_limit;
    logic [mmss_pkg::CNT_W-1:0]    r_second_limit, n_second_limit;

    logic                          at_limit;
    logic                          btn_move;
    logic [mmss_pkg::POT_W-1:0]    pot_masked;
    logic [15:0]                   pot_prod;
    logic [mmss_pkg::CNT_W-1:0]    pot_scaled;

    assign at_limit   = (r_minutes == r_minute_limit) && (r_seconds == r_second_limit);
    assign btn_move   = r_phase[0] ? !i_set_button : i_set_button;
    assign pot_masked = i_pot_reading
                        & mmss_pkg::POT_W'((1 << mmss_pkg::ADC_BITS) - 1);
    assign pot_prod   = 16'(pot_masked) * 16'(mmss_pkg::POT_SCALE);
    assign pot_scaled = mmss_pkg::CNT_W'(pot_prod >> mmss_pkg::ADC_BITS);

    // next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            mmss_pkg::PH_COUNT: begin
                if (i_tick && at_limit) begin
                    n_phase = mmss_pkg::PH_IDLE;
                end
            end
            mmss_pkg::PH_IDLE,
            mmss_pkg::PH_ARM_MIN,
            mmss_pkg::PH_SET_MIN,
            mmss_pkg::PH_ARM_SEC,
            mmss_pkg::PH_SET_SEC,
            mmss_pkg::PH_ARM_RUN: begin
                if (btn_move) begin
                    n_phase = mmss_pkg::t_phase'(r_phase + 3'd1);
                end
            end
            default: begin
                n_phase = mmss_pkg::PH_IDLE;
            end
        endcase
    end

    // counters and limits
    always_comb begin
        n_minutes      = r_minutes;
        n_seconds      = r_seconds;
        n_minute_limit = r_minute_limit;
        n_second_limit = r_second_limit;
        if (r_phase == mmss_pkg::PH_COUNT) begin
            if (i_tick && !at_limit) begin
                if (r_seconds >= mmss_pkg::SEC_LAST) begin
                    n_seconds = '0;
                    n_minutes = r_minutes + 6'd1;
                end else begin
                    n_seconds = r_seconds + 6'd1;
                end
            end
        end else begin
            unique case (n_phase)
                mmss_pkg::PH_SET_MIN: n_minutes = pot_scaled;
                mmss_pkg::PH_SET_SEC: n_seconds = pot_scaled;
                mmss_pkg::PH_COUNT: begin
                    n_minute_limit = r_minutes;
                    n_second_limit = r_seconds;
                    n_minutes      = '0;
                    n_seconds      = '0;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        o_shown.phase = n_phase;
        if (n_phase == mmss_pkg::PH_IDLE) begin
            o_shown.minutes = n_minute_limit;
            o_shown.seconds = n_second_limit;
        end else begin
            o_shown.minutes = n_minutes;
            o_shown.seconds = n_seconds;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= mmss_pkg::PH_IDLE;
            r_minutes      <= '0;
            r_seconds      <= '0;
            r_minute_limit <= '0;
            r_second_limit <= '0;
        end else if (i_step) begin
            r_phase        <= n_phase;
            r_minutes      <= n_minutes;
            r_seconds      <= n_seconds;
            r_minute_limit <= n_minute_limit;
            r_second_limit <= n_second_limit;
        end
    end

    a_count_entry_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && r_phase == mmss_pkg::PH_ARM_RUN && n_phase == mmss_pkg::PH_COUNT
        |=> r_minutes == '0 && r_seconds == '0)
        else $error("counters not cleared on entering count");

    a_count_seconds_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == mmss_pkg::PH_COUNT |-> r_seconds <= mmss_pkg::SEC_LAST)
        else $error("seconds out of range while counting");

    a_limit_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && r_phase == mmss_pkg::PH_COUNT && i_tick && at_limit
        |=> r_phase == mmss_pkg::PH_IDLE)
        else $error("run did not end at the limits");

endmodule

// ----- sv/mmss_disp.sv -----
`timescale 1ns / 1ps
// seven-segment digit decode and phase indicators of the timer
// depends on mmss_pkg

module mmss_disp (
    input  mmss_pkg::t_shown              i_shown,
    output logic [mmss_pkg::SEG_W-1:0]    o_min_tens_seg,
    output logic [mmss_pkg::SEG_W-1:0]    o_min_ones_seg,
    output logic [mmss_pkg::SEG_W-1:0]    o_sec_tens_seg,
    output logic [mmss_pkg::SEG_W-1:0]    o_sec_ones_seg,
    output logic [mmss_pkg::LED_W-1:0]    o_phase_leds,
    output logic                          o_counting
);

    assign o_min_tens_seg = mmss_pkg::seg_of({1'b0, mmss_pkg::tens_of(i_shown.minutes)});
    assign o_min_ones_seg = mmss_pkg::seg_of(mmss_pkg::ones_of(i_shown.minutes));
    assign o_sec_tens_seg = mmss_pkg::seg_of({1'b0, mmss_pkg::tens_of(i_shown.seconds)});
    assign o_sec_ones_seg = mmss_pkg::seg_of(mmss_pkg::ones_of(i_shown.seconds));

    always_comb begin
        o_counting = 1'b0;
        unique case (i_shown.phase) inside
            mmss_pkg::PH_IDLE, mmss_pkg::PH_ARM_MIN:    o_phase_leds = 4'b0001;
            mmss_pkg::PH_SET_MIN, mmss_pkg::PH_ARM_SEC: o_phase_leds = 4'b0010;
            mmss_pkg::PH_SET_SEC, mmss_pkg::PH_ARM_RUN: o_phase_leds = 4'b0100;
            mmss_pkg::PH_COUNT: begin
                o_phase_leds = 4'b1000;
                o_counting   = 1'b1;
            end
            default: o_phase_leds = 4'b0001;
        endcase
    end

endmodule

// ----- bench/mmss_timer_tb_pkg.sv -----
`timescale 1ns / 1ps
// display tracker for the mm:ss timer bench: follows the phase, counters and limits
// depends on mmss_pkg for the phase encoding and ADC_BITS

package mmss_timer_tb_pkg;

    typedef struct {
        logic [6:0] min_tens;
        logic [6:0] min_ones;
        logic [6:0] sec_tens;
        logic [6:0] sec_ones;
        logic [3:0] leds;
        logic       counting;
    } t_display;

    class t_display_tracker;

        mmss_pkg::t_phase phase;
        logic [5:0]       minutes;
        logic [5:0]       seconds;
        logic [5:0]       minute_limit;
        logic [5:0]       second_limit;
        t_display         expected_displays[$];
        int               errors;

        function new();
            phase        = mmss_pkg::PH_IDLE;
            minutes      = '0;
            seconds      = '0;
            minute_limit = '0;
            second_limit = '0;
            errors       = 0;
        endfunction

        function logic [6:0] segments(int d);
            logic [6:0] pattern;
            case (d)
                0: pattern = 7'b1111110;
                1: pattern = 7'b0110000;
                2: pattern = 7'b1101101;
                3: pattern = 7'b1111001;
                4: pattern = 7'b0110011;
                5: pattern = 7'b1011011;
                6: pattern = 7'b1011111;
                7: pattern = 7'b1110000;
                8: pattern = 7'b1111111;
                9: pattern = 7'b1111011;
                default: pattern = 7'b0000000;
            endcase
            return pattern;
        endfunction

        function logic [5:0] scaled(logic [9:0] pot);
            int unsigned prod;
            prod = (int'(pot) & ((1 << mmss_pkg::ADC_BITS) - 1)) * 60;
            return 6'(prod >> mmss_pkg::ADC_BITS);
        endfunction

        // one sample in, one display word expected out
        function void note_sample(bit btn, logic [9:0] pot, bit tick);
            t_display   d;
            int         shown_m;
            int         shown_s;
            if (phase == mmss_pkg::PH_COUNT) begin
                if (tick) begin
                    if (minutes == minute_limit && seconds == second_limit) begin
                        phase = mmss_pkg::PH_IDLE;
                    end else if (seconds >= 6'd59) begin
                        seconds = '0;
                        minutes = minutes + 6'd1;
                    end else begin
                        seconds = seconds + 6'd1;
                    end
                end
            end else begin
                if (phase[0] ? !btn : btn) begin
                    phase = mmss_pkg::t_phase'(phase + 3'd1);
                end
                case (phase)
                    mmss_pkg::PH_SET_MIN: minutes = scaled(pot);
                    mmss_pkg::PH_SET_SEC: seconds = scaled(pot);
                    mmss_pkg::PH_COUNT: begin
                        minute_limit = minutes;
                        second_limit = seconds;
                        minutes      = '0;
                        seconds      = '0;
                    end
                    default: ;
                endcase
            end
            shown_m = (phase == mmss_pkg::PH_IDLE) ? int'(minute_limit) : int'(minutes);
            shown_s = (phase == mmss_pkg::PH_IDLE) ? int'(second_limit) : int'(seconds);
            d.min_tens = segments(shown_m / 10);
            d.min_ones = segments(shown_m % 10);
            d.sec_tens = segments(shown_s / 10);
            d.sec_ones = segments(shown_s % 10);
            d.leds     = (phase == mmss_pkg::PH_COUNT) ? 4'b1000
                                                       : 4'(4'b0001 << (phase >> 1));
            d.counting = (phase == mmss_pkg::PH_COUNT);
            expected_displays.push_back(d);
        endfunction

        function void check_display(logic [39:0] word);
            t_display d;
            t_display got;
            got.min_tens = word[6:0];
            got.min_ones = word[13:7];
            got.sec_tens = word[20:14];
            got.sec_ones = word[27:21];
            got.leds     = word[31:28];
            got.counting = word[32];
            if (expected_displays.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("unexpected result %h", word);
                end
                return;
            end
            d = expected_displays.pop_front();
            if (got.min_tens !== d.min_tens || got.min_ones !== d.min_ones ||
                got.sec_tens !== d.sec_tens || got.sec_ones !== d.sec_ones ||
                got.leds !== d.leds || got.counting !== d.counting) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch: exp seg %h %h %h %h leds %b cnt %b",
                             d.min_tens, d.min_ones, d.sec_tens, d.sec_ones,
                             d.leds, d.counting);
                    $display("          got seg %h %h %h %h leds %b cnt %b",
                             got.min_tens, got.min_ones, got.sec_tens, got.sec_ones,
                             got.leds, got.counting);
                end
            end
        endfunction

        function int pending();
            return expected_displays.size();
        endfunction

    endclass

endpackage

// ----- bench/set_and_count_minute_second_timer_tb.sv -----
`timescale 1ns / 1ps
// bench for the mm:ss timer: directed set/count run, then random runs and noise
// depends on mmss_pkg, mmss_timer_tb_pkg and set_and_count_minute_second_timer

module set_and_count_minute_second_timer_tb;

    localparam int STALL_LIMIT = 1000;
    localparam int N_ITEMS     = 1700;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // set_button[0], pot_reading[10:1], tick[11], zero[15:12]
    logic [15:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // min_tens_seg[6:0], min_ones_seg[13:7], sec_tens_seg[20:14],
    // sec_ones_seg[27:21], phase_leds[31:28], counting[32], zero[39:33]
    logic [39:0] m_tdata;

    mmss_timer_tb_pkg::t_display_tracker tracker = new();
    int idle_pct   = 25;
    int n_sent     = 0;
    int stall_cnt  = 0;

    set_and_count_minute_second_timer dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(99) >= idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            tracker.check_display(m_tdata);
        end
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cnt <= 0;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
        if (stall_cnt >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_sample(bit btn, logic [9:0] pot, bit tick);
        // long stretch with no idling in the middle of the random part
        idle_pct = (n_sent >= 700 && n_sent < 1100) ? 0 : 25;
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, tick, pot, btn};
        do @(posedge i_clk); while (!s_tready);
        tracker.note_sample(btn, pot, tick);
        n_sent++;
    endtask

    task automatic noise_burst();
        int         n;
        logic [9:0] pot;
        n = int'($urandom_range(8, 1));
        repeat (n) begin
            pot = 10'($urandom);
            // a minute set here keeps the later count short
            if (tracker.phase == mmss_pkg::PH_ARM_MIN ||
                tracker.phase == mmss_pkg::PH_SET_MIN) begin
                pot = 10'($urandom_range(60));
            end
            send_sample(1'($urandom_range(1)), pot, 1'($urandom_range(1)));
        end
    endtask

    // walk the setting phases from wherever they stand, then count to the limits
    task automatic set_and_count_run();
        bit         advance;
        logic [9:0] pot;
        while (tracker.phase != mmss_pkg::PH_COUNT) begin
            advance = ($urandom_range(99) < 60);
            pot     = 10'($urandom);
            if (tracker.phase == mmss_pkg::PH_SET_MIN && advance) begin
                // keep minute limits short so the count stays cheap
                pot = ($urandom_range(99) < 60) ? 10'($urandom_range(17))
                                                : 10'($urandom_range(60));
                send_sample(1'b0, pot, 1'($urandom_range(1)));
                pot = 10'($urandom);
            end
            if (tracker.phase == mmss_pkg::PH_ARM_MIN && advance) begin
                pot = 10'($urandom_range(17));
            end
            send_sample(tracker.phase[0] ? !advance : advance, pot,
                        1'($urandom_range(1)));
        end
        while (tracker.phase == mmss_pkg::PH_COUNT) begin
            send_sample(1'($urandom_range(1)), 10'($urandom), $urandom_range(99) < 60);
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // idle, tick ignored
        send_sample(1'b0, 10'd1023, 1'b1);
        send_sample(1'b0, 10'd0, 1'b1);
        // to minute arm, wrong level holds
        send_sample(1'b1, 10'd0, 1'b1);
        send_sample(1'b1, 10'd1023, 1'b0);
        // minute set follows the pot
        send_sample(1'b0, 10'd1023, 1'b1);
        send_sample(1'b0, 10'd512, 1'b0);
        send_sample(1'b0, 10'd0, 1'b0);
        send_sample(1'b1, 10'd1023, 1'b0);
        send_sample(1'b1, 10'd1023, 1'b1);
        // second set
        send_sample(1'b0, 10'd1023, 1'b0);
        send_sample(1'b0, 10'd35, 1'b1);
        send_sample(1'b1, 10'd1023, 1'b0);
        // entering count, tick on the same transfer ignored
        send_sample(1'b0, 10'd1023, 1'b1);
        send_sample(1'b1, 10'd1023, 1'b0);
        send_sample(1'b0, 10'd0, 1'b1);
        send_sample(1'b1, 10'd1023, 1'b1);
        send_sample(1'b0, 10'd0, 1'b1);
        // in idle with the limits shown, then to minute arm and minute set
        send_sample(1'b0, 10'd0, 1'b1);
        send_sample(1'b1, 10'd0, 1'b1);
        send_sample(1'b0, 10'd1023, 1'b0);

        while (n_sent < N_ITEMS) begin
            if ($urandom_range(99) < 80) begin
                set_and_count_run();
            end else begin
                noise_burst();
            end
        end
        s_tvalid <= 1'b0;

        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
